/* src/hst_pkg.sv */
// Shared types, sizes and codes for the hash set table.
package hst_pkg;

   // table geometry; the bucket count is a power of two so the bucket is the key's low bits
   localparam int BUCKET_BITS = 7;
   localparam int BUCKETS     = 1 << BUCKET_BITS;
   localparam int WAYS        = 4;
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 31;
   localparam int STATUS_W = 2;

   // bucket row: every way's key from the bottom up, then one valid mark per way
   localparam int MASK_LSB = WAYS * KEY_W;
   localparam int ROW_W    = MASK_LSB + WAYS;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   // front-to-back queue
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   // operation codes as they arrive on the bus
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TEST   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_UNCHANGED = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_LOOK  = 3'b100
   } back_state_type;

   typedef struct packed {
      op_type                 op;
      logic [BUCKET_BITS-1:0] bucket;
      logic [KEY_W-1:0]       key;
   } queue_entry_type;

   typedef struct packed {
      logic                   wr_en;
      logic [BUCKET_BITS-1:0] wr_addr;
      logic                   rd_en;
      logic [BUCKET_BITS-1:0] rd_addr;
   } ram_ctrl_type;

endpackage

/* src/hst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/hst_queue.sv */
// Short queue that decouples the classifying front from the table back end.
module hst_queue import hst_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            pop_valid,
   output queue_entry_type pop_entry
);

   queue_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* src/hst_front.sv */
// Input stage: takes requests, decodes the operation and picks the bucket.
module hst_front import hst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [KEY_W-1:0]  req_key,
   output logic              push,
   output queue_entry_type   push_entry,
   input  logic              queue_full
);

   logic            item_valid_ff, item_valid_in;
   queue_entry_type item_ff;
   queue_entry_type decoded;
   logic            accept;

   always_comb begin
      decoded.key    = req_key;
      decoded.bucket = req_key[BUCKET_BITS-1:0];
      unique case (req_func)
         FUNC_ADD:    decoded.op = OP_ADD;
         FUNC_REMOVE: decoded.op = OP_REMOVE;
         default:     decoded.op = OP_TEST;   // unused code behaves as a lookup
      endcase
   end

   assign push       = item_valid_ff && !queue_full;
   assign req_tready = !item_valid_ff || !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push_entry = item_ff;

   assign item_valid_in = accept || (item_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= decoded;
      end
   end

endmodule

/* src/hst_back.sv */
// Back end: reads a bucket row, compares all ways, writes back and forms the response.
module hst_back import hst_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  queue_entry_type q_entry,
   output logic            q_pop,
   output ram_ctrl_type    ram_ctrl,
   output logic [ROW_W-1:0] ram_wr_data,
   input  logic [ROW_W-1:0] ram_rd_data,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic            rsp_present,
   output status_type      rsp_status
);

   back_state_type          state_ff, state_in;
   queue_entry_type         cur_ff;
   logic                    fwd_ff, fwd_in;
   logic [ROW_W-1:0]        fwd_row_ff;
   logic [BUCKET_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_present_ff;
   status_type              rsp_status_ff;

   logic [ROW_W-1:0]        row;
   logic [ROW_W-1:0]        new_row;
   logic [WAYS-1:0]         vmask;
   logic [WAYS-1:0]         new_mask;
   logic                    found;
   logic                    has_free;
   logic [WAY_BITS-1:0]     hit_way;
   logic [WAY_BITS-1:0]     free_way;
   logic                    set_bit;
   logic                    clr_bit;
   status_type              status;
   logic                    done;
   logic                    same_bucket;
   logic                    clr_last;

   // tag compare over the row; lowest-numbered way wins for both hit and free slot
   always_comb begin
      row      = fwd_ff ? fwd_row_ff : ram_rd_data;
      vmask    = row[MASK_LSB +: WAYS];
      found    = 1'b0;
      has_free = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (vmask[w] && (row[w*KEY_W +: KEY_W] == cur_ff.key)) begin
            found   = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!vmask[w]) begin
            has_free = 1'b1;
            free_way = WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      status  = ST_DONE;
      set_bit = 1'b0;
      clr_bit = 1'b0;
      case (cur_ff.op)
         OP_ADD: begin
            if (found) begin
               status = ST_UNCHANGED;
            end else if (has_free) begin
               set_bit = 1'b1;
            end else begin
               status = ST_FULL;
            end
         end
         OP_REMOVE: begin
            if (found) begin
               clr_bit = 1'b1;
            end else begin
               status = ST_UNCHANGED;
            end
         end
         default: ;
      endcase

      new_row  = row;
      new_mask = vmask;
      if (set_bit) begin
         new_row[free_way*KEY_W +: KEY_W] = cur_ff.key;
         new_mask[free_way]               = 1'b1;
      end
      if (clr_bit) begin
         new_mask[hit_way] = 1'b0;
      end
      new_row[MASK_LSB +: WAYS] = new_mask;
   end

   assign done        = (state_ff == S_LOOK) && (!rsp_valid_ff || rsp_tready);
   assign q_pop       = q_valid && ((state_ff == S_IDLE) || done);
   assign same_bucket = (q_entry.bucket == cur_ff.bucket);

   // a follower to the same bucket takes the freshly written row instead of the RAM
   assign fwd_in = q_pop && done && same_bucket;

   // clearing pass after reset walks every row once
   assign clr_last    = (clr_addr_ff == BUCKET_BITS'(BUCKETS - 1));
   assign clr_addr_in = (state_ff == S_CLEAR) ? clr_addr_ff + BUCKET_BITS'(1) : clr_addr_ff;

   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_ctrl.wr_en   = 1'b1;
         ram_ctrl.wr_addr = clr_addr_ff;
      end else begin
         ram_ctrl.wr_en   = done && (set_bit || clr_bit);
         ram_ctrl.wr_addr = cur_ff.bucket;
      end
      ram_ctrl.rd_en   = q_pop && !fwd_in;
      ram_ctrl.rd_addr = q_entry.bucket;
   end
   assign ram_wr_data = (state_ff == S_CLEAR) ? '0 : new_row;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_pop) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (done) begin
               state_in = q_pop ? S_LOOK : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
      if (done) begin
         fwd_row_ff     <= new_row;
         rsp_present_ff <= found;
         rsp_status_ff  <= status;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;
   assign rsp_status  = rsp_status_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) && rsp_valid_ff && !rsp_tready |=> (state_ff == S_LOOK))
      else $error("lookup left while response stalled");

   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_LOOK))
      else $error("response raised without a lookup");

   a_full_not_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FULL) |-> !rsp_present_ff)
      else $error("full bucket reported with key present");

   a_write_when_allowed: assert property (@(posedge clock) disable iff (reset)
      ram_ctrl.wr_en |-> (state_ff == S_CLEAR) ||
                         ((state_ff == S_LOOK) && (cur_ff.op != OP_TEST)))
      else $error("row write outside clearing or an updating lookup");

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !q_pop)
      else $error("queue popped during the clearing pass");

endmodule

/* src/hash_set_table.sv */
// Top level of the hash set table: front, queue, back end and bucket row RAM.
// Path: front register, queue slot, RAM read register, then the response register.
// Throughput: up to one transfer per cycle; each bucket lookup reads one RAM row
// into its read register and compares/writes it back from there, a same-bucket follower takes
// the written row by forwarding. A stalled response holds the back end.
// Reset (synchronous, active high) starts a pass that zeroes all 128 rows,
// valid marks included; requests taken meanwhile wait in the front and the queue.
module hash_set_table import hst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [30:0] key, [31] zero
   input  logic [FUNC_W-1:0]     req_tuser,   // [1:0] func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [0] was_present, [2:1] status, [7:3] zero
);

   logic             push;
   queue_entry_type  push_entry;
   logic             queue_full;
   logic             q_pop;
   logic             q_valid;
   queue_entry_type  q_entry;
   ram_ctrl_type     ram_ctrl;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] ram_rd_data;
   logic             rsp_present;
   status_type       rsp_status;

   // front end: decode and bucket select
   hst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .req_key    (req_tdata[KEY_W-1:0]),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // decoupling queue
   hst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   // back end: clearing pass, row compare, update and response register
   hst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .ram_ctrl    (ram_ctrl),
      .ram_wr_data (ram_wr_data),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_present (rsp_present),
      .rsp_status  (rsp_status)
   );

   // one row per bucket holding every way's key and the ways' valid marks
   hst_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_ctrl.wr_en),
      .wr_addr (ram_ctrl.wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_ctrl.rd_en),
      .rd_addr (ram_ctrl.rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata = {(RSP_DATA_W-STATUS_W-1)'(0), rsp_status, rsp_present};

endmodule

/* tb/sv/hash_set_table_test.sv */
// Self-checking regression for the hash set table: directed, random and back-pressure tests.
`timescale 1ns / 1ps

module hash_set_table_test;
   import hst_pkg::*;

   // ---------------------------------------------------------------------------------------
   // constants
   // ---------------------------------------------------------------------------------------
   localparam logic [FUNC_W-1:0] FUNC_TEST  = OP_TEST;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;     // unused code, behaves as a lookup
   localparam logic [KEY_W-1:0]  KEY_MAX    = {KEY_W{1'b1}};

   localparam int HOT_BUCKETS  = 6;      // buckets the churn traffic is squeezed into
   localparam int STALL_LIMIT  = 2000;   // cycles without any transfer before giving up
   localparam int HOLD_CYCLES  = 200;    // long receiver hold-off in the pressure test
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic              was_present;
      status_type        status;
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
   } set_answer;

   // ---------------------------------------------------------------------------------------
   // DUT and its stimulus
   // ---------------------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;     // [30:0] key, [31] zero
   logic [FUNC_W-1:0]     req_tuser;     // [1:0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;     // [0] was_present, [2:1] status, [7:3] zero

   hash_set_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // shared state
   // ---------------------------------------------------------------------------------------
   // shadow copy of the bucket rows; valid marks start clear as after reset
   logic [KEY_W-1:0]       bucket_key   [BUCKETS][WAYS];
   bit                     bucket_valid [BUCKETS][WAYS];
   set_answer              answers_due[$];        // predicted responses, oldest first
   logic [BUCKET_BITS-1:0] hot_bucket [HOT_BUCKETS];
   logic [KEY_W-1:0]       last_key = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;   // set by a test, consumed by the receiver process
   int errors         = 0;

   function automatic void report_fault(string msg);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // Applies one operation to the shadow table and returns the answer it must give.
   // A hit is the first valid way holding the key; an add takes the lowest free way.
   function automatic set_answer apply_op(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
      set_answer   ans;
      int unsigned b;
      int          hit_way;
      int          free_way;
      b        = key % BUCKETS;
      hit_way  = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (bucket_valid[b][w]) begin
            if (hit_way < 0 && bucket_key[b][w] == key)
               hit_way = w;
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      ans.func        = func;
      ans.key         = key;
      ans.was_present = (hit_way >= 0);
      ans.status      = ST_DONE;
      if (func == FUNC_ADD) begin
         if (hit_way >= 0) begin
            ans.status = ST_UNCHANGED;
         end else if (free_way >= 0) begin
            bucket_key[b][free_way]   = key;
            bucket_valid[b][free_way] = 1'b1;
         end else begin
            ans.status = ST_FULL;
         end
      end else if (func == FUNC_REMOVE) begin
         if (hit_way >= 0)
            bucket_valid[b][hit_way] = 1'b0;
         else
            ans.status = ST_UNCHANGED;
      end
      // lookups and the spare code leave the table alone
      return ans;
   endfunction

   // ---------------------------------------------------------------------------------------
   // sender: called at a falling edge, returns at the falling edge after the transfer.
   // tvalid is left high so a back-to-back item keeps it up without a glitch.
   // ---------------------------------------------------------------------------------------
   task automatic send_op(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-KEY_W){1'b0}}, key};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      answers_due.push_back(apply_op(func, key));
      @(negedge clock);
   endtask

   // drops tvalid and waits for every outstanding response
   task automatic drain();
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   // 40% adds, 30% removes, 25% lookups and 5% spare codes
   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(99);
      if (r < 40)
         return FUNC_ADD;
      else if (r < 70)
         return FUNC_REMOVE;
      else if (r < 95)
         return FUNC_TEST;
      return FUNC_SPARE;
   endfunction

   // few buckets and few distinct upper parts, so hits, duplicates and full buckets are common
   function automatic logic [KEY_W-1:0] churn_key();
      logic [KEY_W-BUCKET_BITS-1:0] upper;
      upper = ($urandom_range(9) == 0) ? (KEY_W-BUCKET_BITS)'($urandom())
                                       : (KEY_W-BUCKET_BITS)'($urandom_range(5));
      return {upper, hot_bucket[$urandom_range(HOT_BUCKETS-1)]};
   endfunction

   // ---------------------------------------------------------------------------------------
   // response checker: compares each transfer with the oldest prediction
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      set_answer due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers_due.size() == 0) begin
            report_fault($sformatf("response 0x%02h with nothing outstanding", rsp_tdata));
         end else begin
            due = answers_due.pop_front();
            if (rsp_tdata[0] !== due.was_present || rsp_tdata[2:1] !== due.status ||
                rsp_tdata[RSP_DATA_W-1:3] !== '0)
               report_fault($sformatf(
                  "func %0d key 0x%08h: expected %0d/%0d, got %0d/%0d pad 0x%0h",
                  due.func, due.key, due.was_present, due.status,
                  rsp_tdata[0], rsp_tdata[2:1], rsp_tdata[RSP_DATA_W-1:3]));
         end
      end
   end

   // receiver: random stalls, or one long hold-off when a test asks for it
   initial begin : receiver
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            n            = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog: a run that stops moving on both channels is a hang
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("hash_set_table regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // corner cases on bucket 0 and the top bucket, no idling
   task automatic test_directed();
      set_idling(0, 0);
      send_op(FUNC_TEST,   '0);                           // lookup in an empty table
      send_op(FUNC_REMOVE, '0);                           // remove of an absent key
      send_op(FUNC_ADD,    '0);                           // first add
      send_op(FUNC_ADD,    '0);                           // duplicate add
      send_op(FUNC_TEST,   '0);
      send_op(FUNC_SPARE,  '0);                           // spare code acts as a lookup
      send_op(FUNC_ADD,    KEY_W'(BUCKETS));              // fill the remaining ways of bucket 0
      send_op(FUNC_ADD,    KEY_W'(2 * BUCKETS));
      send_op(FUNC_ADD,    KEY_W'(3 * BUCKETS));
      send_op(FUNC_ADD,    KEY_W'(4 * BUCKETS));          // bucket full, refused
      send_op(FUNC_TEST,   KEY_W'(4 * BUCKETS));          // refused key must be absent
      send_op(FUNC_REMOVE, KEY_W'(2 * BUCKETS));          // frees a middle way
      send_op(FUNC_ADD,    KEY_W'(4 * BUCKETS));          // lands in the freed way
      send_op(FUNC_TEST,   KEY_W'(2 * BUCKETS));
      send_op(FUNC_REMOVE, KEY_W'(4 * BUCKETS));
      send_op(FUNC_ADD,    KEY_MAX);                      // largest key, top bucket
      send_op(FUNC_TEST,   KEY_MAX);
      send_op(FUNC_ADD,    KEY_W'(KEY_MAX - BUCKETS));
      send_op(FUNC_ADD,    KEY_W'(BUCKETS - 1));
      send_op(FUNC_ADD,    KEY_W'(2 * BUCKETS - 1));
      send_op(FUNC_ADD,    KEY_W'(3 * BUCKETS - 1));      // top bucket full
      send_op(FUNC_SPARE,  KEY_MAX);
      send_op(FUNC_REMOVE, KEY_MAX);
      send_op(FUNC_REMOVE, KEY_MAX);                      // second remove finds nothing
      send_op(FUNC_TEST,   KEY_MAX);
      drain();
   endtask

   // well-formed traffic concentrated on a few buckets, across the idling phases
   task automatic test_bucket_churn();
      int send_pcts  [4] = '{0, 55, 0, 10};
      int stall_pcts [4] = '{0, 0, 55, 10};
      for (int p = 0; p < 4; p++) begin
         set_idling(send_pcts[p], stall_pcts[p]);
         foreach (hot_bucket[i])
            hot_bucket[i] = BUCKET_BITS'($urandom_range(BUCKETS - 1));
         repeat (300)
            send_op(pick_func(), churn_key());
         drain();
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming, so the
   // internal queue fills and req_tready must drop
   task automatic test_back_pressure();
      set_idling(0, 0);
      foreach (hot_bucket[i])
         hot_bucket[i] = BUCKET_BITS'($urandom_range(BUCKETS - 1));
      hold_request = HOLD_CYCLES;
      repeat (60)
         send_op(pick_func(), churn_key());
      drain();
   endtask

   // full-width random keys, reusing the previous key now and then to get some hits
   task automatic test_sparse_keys();
      logic [KEY_W-1:0] key;
      set_idling(10, 10);
      repeat (200) begin
         key = ($urandom_range(3) == 0) ? last_key : KEY_W'($urandom());
         last_key = key;
         send_op(pick_func(), key);
      end
      drain();
   endtask

   // ---------------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_bucket_churn();
      test_back_pressure();
      test_sparse_keys();

      // let any stray transfer show up before the verdict
      repeat (20) @(posedge clock);
      if (answers_due.size() != 0)
         report_fault($sformatf("%0d responses never arrived", answers_due.size()));
      if (errors == 0)
         $display("hash_set_table regression: pass");
      else
         $display("hash_set_table regression: fail");
      $finish;
   end

endmodule
